>>> rtl/gcce_pkg.sv
// Shared types and constants for the grid circle cell enumerator.
// Holds the request and result payload structs and the register codes.
// Used by the front end, back end, top level and checker; depends on nothing.
package gcce_pkg;

  localparam int COORD_W     = 18;
  localparam int INDEX_W     = 12;
  localparam int SHIFT_W     = 4;
  localparam int DIM_REG_W   = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;

  localparam int SHIFT_MIN   = 3;
  localparam int SHIFT_MAX   = 12;
  localparam int SHIFT_RESET = 8;
  localparam int DIM_RESET   = 64;
  localparam int RESULT_CAP  = 64;

  // Lengths are scaled so that half a cell and 0.72 of a cell are whole numbers.
  // The test becomes 625 * (ex^2 + ez^2) < (25 * r + 18 * cell)^2.
  localparam int TH_R_MUL    = 25;
  localparam int TH_CELL_MUL = 18;
  localparam int DIST_SQ_MUL = 625;
  localparam int DIST_MUL_W  = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CELL_SHIFT = 2'd0,
    CFG_GRID_COLS  = 2'd1,
    CFG_GRID_ROWS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_z;
    logic [COORD_W-1:0] query_radius;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic               last_cell;
  } out_t;

endpackage

>>> rtl/gcce_front.sv
// Front end: accepts query requests, clamps them and works out the cell window.
// Produces one job per request for the queue; uses gcce_pkg.
module gcce_front #(
  parameter int MAX_GRID_DIM = 64,
  parameter int MAX_SPAN     = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  gcce_pkg::in_t                          in_data,
  input  logic [gcce_pkg::SHIFT_W-1:0]           sh,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      cols,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      rows,
  output logic                                   job_valid,
  input  logic                                   job_full,
  output logic [gcce_pkg::COORD_W-1:0]           job_px,
  output logic [gcce_pkg::COORD_W-1:0]           job_pz,
  output logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_x0,
  output logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_x1,
  output logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_z0,
  output logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_z1,
  output logic [gcce_pkg::INDEX_W-1:0]           job_rb,
  output logic [2*($clog2((MAX_SPAN-1)/2+2)+gcce_pkg::SHIFT_MAX+6)-1:0] job_tsq
);

  localparam int DIM_W   = $clog2(MAX_GRID_DIM + 1);
  localparam int RAD_C   = (MAX_SPAN - 1) / 2;
  localparam int RC_W    = $clog2(RAD_C + 2);
  localparam int R_W     = RC_W + gcce_pkg::SHIFT_MAX;
  localparam int T_W     = R_W + 6;
  localparam int TSQ_W   = 2 * T_W;
  localparam int CW      = gcce_pkg::COORD_W;
  localparam int S_W     = CW + 1;
  localparam int MAP_W   = DIM_W + gcce_pkg::SHIFT_MAX;
  localparam int CL_W    = (MAP_W > CW) ? MAP_W : CW;
  localparam int RB_W    = 2 * DIM_W;

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] p,
                                                input logic [DIM_W-1:0] n,
                                                input logic [gcce_pkg::SHIFT_W-1:0] s);
    logic [CL_W-1:0] lim;
    lim = (CL_W'(n) << s) - CL_W'(1);
    return (CL_W'(p) > lim) ? CW'(lim) : p;
  endfunction

  function automatic logic [DIM_W-1:0] win_edge(input logic [S_W-1:0] v,
                                                input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] nm1;
    nm1 = n - DIM_W'(1);
    return (v > S_W'(nm1)) ? nm1 : DIM_W'(v);
  endfunction

  logic              a_v_r, b_v_r, c_v_r;
  logic              f_adv, accept;
  logic [CW-1:0]     px_a_r, pz_a_r, px_b_r, pz_b_r, px_c_r, pz_c_r;
  logic [R_W-1:0]    r_a_r, r_max, r_sat;
  logic [DIM_W-1:0]  x0_b_r, x1_b_r, z0_b_r, z1_b_r;
  logic [DIM_W-1:0]  x0_c_r, x1_c_r, z0_c_r, z1_c_r;
  logic [DIM_W-1:0]  x0_nxt, x1_nxt, z0_nxt, z1_nxt;
  logic [T_W-1:0]    t_b_r, t_nxt;
  logic [TSQ_W-1:0]  tsq_c_r;
  logic [gcce_pkg::INDEX_W-1:0] rb_c_r;
  logic [S_W-1:0]    lo_x, hi_x, lo_z, hi_z;

  assign f_adv    = !c_v_r || !job_full;
  assign in_stall = !f_adv;
  assign accept   = in_valid && f_adv;

  always_comb begin
    r_max = R_W'(RAD_C) << sh;
    r_sat = (in_data.query_radius > CW'(r_max)) ? r_max : R_W'(in_data.query_radius);
  end

  always_comb begin
    lo_x = (px_a_r >= CW'(r_a_r)) ? ({1'b0, px_a_r - CW'(r_a_r)} >> sh) : '0;
    hi_x = ({1'b0, px_a_r} + S_W'(r_a_r)) >> sh;
    lo_z = (pz_a_r >= CW'(r_a_r)) ? ({1'b0, pz_a_r - CW'(r_a_r)} >> sh) : '0;
    hi_z = ({1'b0, pz_a_r} + S_W'(r_a_r)) >> sh;
    x0_nxt = win_edge(lo_x, cols);
    x1_nxt = win_edge(hi_x, cols);
    z0_nxt = win_edge(lo_z, rows);
    z1_nxt = win_edge(hi_z, rows);
    t_nxt  = T_W'(r_a_r) * T_W'(gcce_pkg::TH_R_MUL) + (T_W'(gcce_pkg::TH_CELL_MUL) << sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (f_adv) begin
      a_v_r <= accept;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      px_a_r  <= clamp_coord(in_data.center_x, cols, sh);
      pz_a_r  <= clamp_coord(in_data.center_z, rows, sh);
      r_a_r   <= r_sat;
      px_b_r  <= px_a_r;
      pz_b_r  <= pz_a_r;
      x0_b_r  <= x0_nxt;
      x1_b_r  <= x1_nxt;
      z0_b_r  <= z0_nxt;
      z1_b_r  <= z1_nxt;
      t_b_r   <= t_nxt;
      px_c_r  <= px_b_r;
      pz_c_r  <= pz_b_r;
      x0_c_r  <= x0_b_r;
      x1_c_r  <= x1_b_r;
      z0_c_r  <= z0_b_r;
      z1_c_r  <= z1_b_r;
      tsq_c_r <= TSQ_W'(t_b_r) * TSQ_W'(t_b_r);
      rb_c_r  <= gcce_pkg::INDEX_W'(RB_W'(z0_b_r) * RB_W'(cols));
    end
  end

  assign job_valid = c_v_r;
  assign job_px    = px_c_r;
  assign job_pz    = pz_c_r;
  assign job_x0    = x0_c_r;
  assign job_x1    = x1_c_r;
  assign job_z0    = z0_c_r;
  assign job_z1    = z1_c_r;
  assign job_rb    = rb_c_r;
  assign job_tsq   = tsq_c_r;

endmodule

>>> rtl/gcce_queue.sv
// Short first-in first-out queue of flat words between the front and back ends.
// Generic width and depth; depends on nothing.
module gcce_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_full,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_full = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/gcce_back.sv
// Back end: walks each window, tests one cell per cycle unless stalled, in a
// four-stage distance pipeline and emits the passing cells; uses gcce_pkg.
module gcce_back #(
  parameter int MAX_GRID_DIM = 64,
  parameter int MAX_SPAN     = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   job_valid,
  output logic                                   job_pop,
  input  logic [gcce_pkg::COORD_W-1:0]           job_px,
  input  logic [gcce_pkg::COORD_W-1:0]           job_pz,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_x0,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_x1,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_z0,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      job_z1,
  input  logic [gcce_pkg::INDEX_W-1:0]           job_rb,
  input  logic [2*($clog2((MAX_SPAN-1)/2+2)+gcce_pkg::SHIFT_MAX+6)-1:0] job_tsq,
  input  logic [gcce_pkg::SHIFT_W-1:0]           sh,
  input  logic [$clog2(MAX_GRID_DIM+1)-1:0]      cols,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output gcce_pkg::out_t                         out_data
);

  localparam int DIM_W  = $clog2(MAX_GRID_DIM + 1);
  localparam int RC_W   = $clog2((MAX_SPAN - 1) / 2 + 2);
  localparam int TSQ_W  = 2 * (RC_W + gcce_pkg::SHIFT_MAX + 6);
  localparam int CW     = gcce_pkg::COORD_W;
  localparam int IW     = gcce_pkg::INDEX_W;
  localparam int E_W    = DIM_W + gcce_pkg::SHIFT_MAX + 2;
  localparam int SQ_W   = 2 * E_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int PROD_W = SUM_W + gcce_pkg::DIST_MUL_W;
  localparam int CMP_W  = (PROD_W > TSQ_W) ? PROD_W : TSQ_W;
  localparam int CNT_W  = $clog2(gcce_pkg::RESULT_CAP + 1);

  logic             active_r, load, issue, adv, x_end, z_end;
  logic [DIM_W-1:0] x_r, z_r, jx0_r, jx1_r, jz1_r;
  logic [IW-1:0]    rb_r;
  logic [CW-1:0]    jpx_r, jpz_r;
  logic [TSQ_W-1:0] jtsq_r;

  logic [E_W-1:0]   xs, zs, half;
  logic             v1_r, v2_r, v3_r, v4_r;
  logic signed [E_W-1:0]  ex1_r, ez1_r;
  logic signed [SQ_W-1:0] sqx2_r, sqz2_r;
  logic [SUM_W-1:0]  sum3_r;
  logic [PROD_W-1:0] prod4_r;
  logic [IW-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic              end1_r, end2_r, end3_r, end4_r;
  logic [TSQ_W-1:0]  tsq1_r, tsq2_r, tsq3_r, tsq4_r;

  logic              pend_valid_r, pend_valid_nxt;
  logic              pend_final_r, pend_final_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  gcce_pkg::out_t    out_data_r, out_data_nxt, emit_data;
  logic              emit, out_free, tail_pass;

  assign load    = !active_r && job_valid;
  assign job_pop = load;
  assign issue   = active_r && adv;
  assign x_end   = (x_r == jx1_r);
  assign z_end   = (z_r == jz1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (issue && x_end && z_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= job_x0;
      z_r    <= job_z0;
      rb_r   <= job_rb;
      jx0_r  <= job_x0;
      jx1_r  <= job_x1;
      jz1_r  <= job_z1;
      jpx_r  <= job_px;
      jpz_r  <= job_pz;
      jtsq_r <= job_tsq;
    end else if (issue) begin
      if (x_end) begin
        x_r  <= jx0_r;
        z_r  <= z_r + 1'b1;
        rb_r <= rb_r + IW'(cols);
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // Offset from the query center to the cell midpoint, in world units.
  always_comb begin
    half = (E_W'(1) << sh) >> 1;
    xs   = E_W'(x_r) << sh;
    zs   = E_W'(z_r) << sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex1_r   <= $signed(xs + half - E_W'(jpx_r));
      ez1_r   <= $signed(zs + half - E_W'(jpz_r));
      idx1_r  <= rb_r + IW'(x_r);
      end1_r  <= x_end && z_end;
      tsq1_r  <= jtsq_r;
      sqx2_r  <= ex1_r * ex1_r;
      sqz2_r  <= ez1_r * ez1_r;
      idx2_r  <= idx1_r;
      end2_r  <= end1_r;
      tsq2_r  <= tsq1_r;
      sum3_r  <= {1'b0, sqx2_r} + {1'b0, sqz2_r};
      idx3_r  <= idx2_r;
      end3_r  <= end2_r;
      tsq3_r  <= tsq2_r;
      prod4_r <= PROD_W'(sum3_r) * PROD_W'(gcce_pkg::DIST_SQ_MUL);
      idx4_r  <= idx3_r;
      end4_r  <= end3_r;
      tsq4_r  <= tsq3_r;
    end
  end

  // One passing cell is held back so that the final one can carry last_cell.
  always_comb begin
    out_free       = !out_valid_r || !out_stall;
    adv            = out_free && !pend_final_r;
    tail_pass      = v4_r && (CMP_W'(prod4_r) < CMP_W'(tsq4_r)) &&
                     (cnt_r < CNT_W'(gcce_pkg::RESULT_CAP));
    emit           = 1'b0;
    emit_data      = '{cell_index: pend_idx_r, last_cell: 1'b0};
    pend_valid_nxt = pend_valid_r;
    pend_final_nxt = pend_final_r;
    pend_idx_nxt   = pend_idx_r;
    cnt_nxt        = cnt_r;
    if (out_free) begin
      if (pend_final_r) begin
        emit                = 1'b1;
        emit_data.last_cell = 1'b1;
        pend_valid_nxt      = 1'b0;
        pend_final_nxt      = 1'b0;
      end else if (v4_r) begin
        if (tail_pass) begin
          cnt_nxt = cnt_r + 1'b1;
          emit    = pend_valid_r;
          if (end4_r) begin
            cnt_nxt = '0;
            if (pend_valid_r) begin
              pend_idx_nxt   = idx4_r;
              pend_final_nxt = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_data = '{cell_index: idx4_r, last_cell: 1'b1};
            end
          end else begin
            pend_idx_nxt   = idx4_r;
            pend_valid_nxt = 1'b1;
          end
        end else if (end4_r) begin
          emit                = pend_valid_r;
          emit_data.last_cell = 1'b1;
          pend_valid_nxt      = 1'b0;
          cnt_nxt             = '0;
        end
      end
    end
    out_valid_nxt = out_free ? emit : out_valid_r;
    out_data_nxt  = emit ? emit_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_final_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_final_r <= pend_final_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/grid_circle_cell_enumerator.sv
// Top level of the grid circle cell enumerator: configuration registers,
// front end, job queue and back end. Uses gcce_pkg, gcce_front, gcce_queue, gcce_back.
//
// A request on the in_ channel carries a circle center and radius. For each
// request the block returns, on the out_ channel, the row-major index of every
// grid cell near enough to the circle, in row-major order; the final result of
// a request has last_cell set. Each request yields between 1 and 64 results.
// The cfg_ channel writes cell_shift, grid_cols and grid_rows; it is always ready.
// The first result passes through three front stages, the queue, the window load,
// four distance stages and the result register. A passing cell then waits in the
// back end until the next passing cell or the end of the window is seen.
// The back end tests one window cell per cycle unless a stalled result or a pending
// final cell holds it, and loads the next request only after the last cell of the
// current window is issued. The front end keeps taking requests while the back end
// works until its two-entry queue fills.
// Reset restores the register defaults and empties every stage and the queue.
// While a result is valid and out_stall is high, it holds and the back end freezes.
module grid_circle_cell_enumerator #(
  parameter int MAX_GRID_DIM = 64,
  parameter int MAX_SPAN     = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gcce_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gcce_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcce_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gcce_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DIM_W   = $clog2(MAX_GRID_DIM + 1);
  localparam int RC_W    = $clog2((MAX_SPAN - 1) / 2 + 2);
  localparam int TSQ_W   = 2 * (RC_W + gcce_pkg::SHIFT_MAX + 6);
  localparam int CW      = gcce_pkg::COORD_W;
  localparam int JOB_W   = 2 * CW + 4 * DIM_W + gcce_pkg::INDEX_W + TSQ_W;
  localparam int Q_DEPTH = 2;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [gcce_pkg::DIM_REG_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (32'(d) > 32'(MAX_GRID_DIM)) begin
      res = DIM_W'(MAX_GRID_DIM);
    end else begin
      res = DIM_W'(d);
    end
    return res;
  endfunction

  logic [gcce_pkg::SHIFT_W-1:0] sh_r;
  logic [DIM_W-1:0]             cols_r, rows_r;
  logic [gcce_pkg::SHIFT_W-1:0] sh_wr;
  logic                         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data[gcce_pkg::SHIFT_W-1:0] < gcce_pkg::SHIFT_W'(gcce_pkg::SHIFT_MIN)) begin
      sh_wr = gcce_pkg::SHIFT_W'(gcce_pkg::SHIFT_MIN);
    end else if (cfg_data[gcce_pkg::SHIFT_W-1:0] >
                 gcce_pkg::SHIFT_W'(gcce_pkg::SHIFT_MAX)) begin
      sh_wr = gcce_pkg::SHIFT_W'(gcce_pkg::SHIFT_MAX);
    end else begin
      sh_wr = cfg_data[gcce_pkg::SHIFT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r   <= gcce_pkg::SHIFT_W'(gcce_pkg::SHIFT_RESET);
      cols_r <= eff_dim(gcce_pkg::DIM_REG_W'(gcce_pkg::DIM_RESET));
      rows_r <= eff_dim(gcce_pkg::DIM_REG_W'(gcce_pkg::DIM_RESET));
    end else if (cfg_wr) begin
      case (cfg_index)
        gcce_pkg::CFG_CELL_SHIFT: sh_r   <= sh_wr;
        gcce_pkg::CFG_GRID_COLS:  cols_r <= eff_dim(cfg_data);
        gcce_pkg::CFG_GRID_ROWS:  rows_r <= eff_dim(cfg_data);
        default: ;
      endcase
    end
  end

  logic                         f_valid, q_full, q_valid, q_pop;
  logic [CW-1:0]                f_px, f_pz, b_px, b_pz;
  logic [DIM_W-1:0]             f_x0, f_x1, f_z0, f_z1, b_x0, b_x1, b_z0, b_z1;
  logic [gcce_pkg::INDEX_W-1:0] f_rb, b_rb;
  logic [TSQ_W-1:0]             f_tsq, b_tsq;
  logic [JOB_W-1:0]             q_in, q_out;

  gcce_front #(
    .MAX_GRID_DIM(MAX_GRID_DIM),
    .MAX_SPAN    (MAX_SPAN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sh       (sh_r),
    .cols     (cols_r),
    .rows     (rows_r),
    .job_valid(f_valid),
    .job_full (q_full),
    .job_px   (f_px),
    .job_pz   (f_pz),
    .job_x0   (f_x0),
    .job_x1   (f_x1),
    .job_z0   (f_z0),
    .job_z1   (f_z1),
    .job_rb   (f_rb),
    .job_tsq  (f_tsq)
  );

  assign q_in = {f_px, f_pz, f_x0, f_x1, f_z0, f_z1, f_rb, f_tsq};

  gcce_queue #(
    .W    (JOB_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_full (q_full),
    .push_data (q_in),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  assign {b_px, b_pz, b_x0, b_x1, b_z0, b_z1, b_rb, b_tsq} = q_out;

  gcce_back #(
    .MAX_GRID_DIM(MAX_GRID_DIM),
    .MAX_SPAN    (MAX_SPAN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_valid),
    .job_pop  (q_pop),
    .job_px   (b_px),
    .job_pz   (b_pz),
    .job_x0   (b_x0),
    .job_x1   (b_x1),
    .job_z0   (b_z0),
    .job_z1   (b_z1),
    .job_rb   (b_rb),
    .job_tsq  (b_tsq),
    .sh       (sh_r),
    .cols     (cols_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> rtl/gcce_checker.sv
// Port-level checks for the grid circle cell enumerator, bound to the top level.
// Uses gcce_pkg for the result type.
module gcce_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input gcce_pkg::out_t out_data
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("request channel stalled right after reset");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind grid_circle_cell_enumerator gcce_checker u_gcce_checker (.*);
